@@ rtl/shp3_pkg.sv @@
// ----------------------------------------------------------------------------
// shp3_pkg: shared types and constants
// Field widths, register indexes, command codes and pipeline flags for the
// 3x3 sharpen filter.
// ----------------------------------------------------------------------------
package shp3_pkg;

  // parameter defaults
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned PIXEL_BITS_DEF = 8;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 16;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 16'd1024;

  // input item kind (tuser)
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // result fields
  localparam int unsigned SHARP_W     = 12;
  localparam int unsigned OUT_COL_W   = 10;
  localparam int unsigned OUT_ROW_W   = 16;
  localparam int unsigned OUT_FIELD_W = SHARP_W + OUT_COL_W + OUT_ROW_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // per-item control carried from the position tracker to the datapath
  typedef struct packed {
    logic emit;       // item produces a result
    logic last;       // result is the frame's final pixel
    logic use_up;
    logic use_down;
    logic use_left;
    logic use_right;
  } flags_t;

endpackage

@@ rtl/shp3_linebuf.sv @@
// ----------------------------------------------------------------------------
// shp3_linebuf: two line stores
// Holds the pixels one and two rows back per column. Clears itself after
// reset, reads on item accept and forwards a same-column write.
// ----------------------------------------------------------------------------
module shp3_linebuf #(
  parameter int unsigned MAX_WIDTH  = shp3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = shp3_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr_i,
  input  logic [PIXEL_BITS-1:0]         wr_pixel_i,
  output logic                          clearing_o,
  output logic [PIXEL_BITS-1:0]         top_o,
  output logic [PIXEL_BITS-1:0]         mid_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam logic [COL_W-1:0] CLR_LAST = COL_W'(MAX_WIDTH - 1);

  logic [PIXEL_BITS-1:0] mem_upper [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] mem_lower [MAX_WIDTH];

  logic [PIXEL_BITS-1:0] raw_upper_q, raw_lower_q;
  logic [PIXEL_BITS-1:0] fwd_upper_q, fwd_lower_q;
  logic                  fwd_q, fwd_d;
  logic                  clearing_q, clearing_d;
  logic [COL_W-1:0]      clr_q, clr_d;

  // the item leaving the stage writes the column the new item reads
  assign fwd_d = wr_en_i && rd_en_i && (wr_addr_i == rd_addr_i);

  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    if (clearing_q) begin
      clr_d = clr_q + COL_W'(1);
      if (clr_q == CLR_LAST) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
      fwd_q      <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
      if (rd_en_i) begin
        fwd_q <= fwd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_upper[clr_q] <= '0;
      mem_lower[clr_q] <= '0;
    end else if (wr_en_i) begin
      mem_upper[wr_addr_i] <= mid_o;
      mem_lower[wr_addr_i] <= wr_pixel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      raw_upper_q <= mem_upper[rd_addr_i];
      raw_lower_q <= mem_lower[rd_addr_i];
      fwd_upper_q <= mid_o;
      fwd_lower_q <= wr_pixel_i;
    end
  end

  assign top_o      = fwd_q ? fwd_upper_q : raw_upper_q;
  assign mid_o      = fwd_q ? fwd_lower_q : raw_lower_q;
  assign clearing_o = clearing_q;

endmodule

@@ rtl/shp3_kernel.sv @@
// ----------------------------------------------------------------------------
// shp3_kernel: window taps, kernel sum and result register
// Shifts the window on every item, forms 5*centre minus the edge
// neighbours inside the image and holds the result for the output side.
// ----------------------------------------------------------------------------
module shp3_kernel #(
  parameter int unsigned MAX_WIDTH  = shp3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = shp3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 shift_i,
  input  logic [PIXEL_BITS-1:0]                top_i,
  input  logic [PIXEL_BITS-1:0]                mid_i,
  input  logic [PIXEL_BITS-1:0]                pixel_i,
  input  shp3_pkg::flags_t                     flags_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]         ecol_i,
  input  logic [shp3_pkg::OUT_ROW_W-1:0]       erow_i,
  output logic                                 out_free_o,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output logic [shp3_pkg::SHARP_W-1:0]         res_sharp_o,
  output logic [shp3_pkg::OUT_COL_W-1:0]       res_col_o,
  output logic [shp3_pkg::OUT_ROW_W-1:0]       res_row_o,
  output logic                                 res_last_o
);

  localparam int unsigned SUM_W = (PIXEL_BITS + 4 > shp3_pkg::SHARP_W) ?
                                  PIXEL_BITS + 4 : shp3_pkg::SHARP_W;

  // window taps: newest column of the upper and lower rows, two of the middle
  logic [PIXEL_BITS-1:0] top2_q, mid1_q, mid2_q, bot2_q;

  logic [SUM_W-1:0] ctr_x5, sum;
  logic             load;
  logic             valid_q, valid_d;

  logic [shp3_pkg::SHARP_W-1:0]   sharp_q;
  logic [shp3_pkg::OUT_COL_W-1:0] col_q;
  logic [shp3_pkg::OUT_ROW_W-1:0] row_q;
  logic                           last_q;

  // taps before this item's shift: up=top2, left=mid1, centre=mid2,
  // right=mid_i, down=bot2
  always_comb begin
    ctr_x5 = (SUM_W'(mid2_q) << 2) + SUM_W'(mid2_q);
    sum    = ctr_x5
           - (flags_i.use_up    ? SUM_W'(top2_q) : '0)
           - (flags_i.use_down  ? SUM_W'(bot2_q) : '0)
           - (flags_i.use_left  ? SUM_W'(mid1_q) : '0)
           - (flags_i.use_right ? SUM_W'(mid_i)  : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top2_q <= '0;
      mid1_q <= '0;
      mid2_q <= '0;
      bot2_q <= '0;
    end else if (shift_i) begin
      top2_q <= top_i;
      mid1_q <= mid2_q;
      mid2_q <= mid_i;
      bot2_q <= pixel_i;
    end
  end

  assign out_free_o = !valid_q || res_ready_i;
  assign load       = shift_i && flags_i.emit;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (res_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sharp_q <= sum[shp3_pkg::SHARP_W-1:0];
      col_q   <= shp3_pkg::OUT_COL_W'(ecol_i);
      row_q   <= erow_i;
      last_q  <= flags_i.last;
    end
  end

  assign res_valid_o = valid_q;
  assign res_sharp_o = sharp_q;
  assign res_col_o   = col_q;
  assign res_row_o   = row_q;
  assign res_last_o  = last_q;

endmodule

@@ rtl/shp3_ctrl.sv @@
// ----------------------------------------------------------------------------
// shp3_ctrl: configuration and raster position tracking
// Holds the size registers, tracks input and result positions, decides per
// item what it does and keeps the item in the read stage.
// ----------------------------------------------------------------------------
module shp3_ctrl #(
  parameter int unsigned MAX_WIDTH  = shp3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = shp3_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [shp3_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [shp3_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              in_cmd_i,
  input  logic [PIXEL_BITS-1:0]             in_pixel_i,
  input  logic                              clearing_i,
  input  logic                              out_free_i,
  output logic                              rd_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr_o,
  output logic                              s1_adv_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      s1_col_o,
  output logic [PIXEL_BITS-1:0]             s1_pixel_o,
  output shp3_pkg::flags_t                  s1_flags_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      s1_ecol_o,
  output logic [shp3_pkg::OUT_ROW_W-1:0]    s1_erow_o
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W  = (WCNT_W > shp3_pkg::WIDTH_REG_W) ?
                                   WCNT_W : shp3_pkg::WIDTH_REG_W;
  localparam int unsigned ROW_W  = shp3_pkg::OUT_ROW_W;
  localparam logic [ROW_W-1:0] ROW_MAX = '1;

  logic [shp3_pkg::WIDTH_REG_W-1:0]  width_q;
  logic [shp3_pkg::HEIGHT_REG_W-1:0] height_q;

  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0] ecol_q, ecol_d;
  logic [ROW_W-1:0] erow_q, erow_d;
  logic             flushing_q, flushing_d;

  logic [WCNT_W-1:0] w_eff;
  logic [ROW_W-1:0]  h_last;
  logic [COL_W-1:0]  col_eff;
  logic [WCNT_W-1:0] col_inc, ecol_inc;
  logic              wrap, ewrap, frame_end, pix_valid, ignore, accept, take;
  logic              flush_n;
  shp3_pkg::flags_t  flags;

  logic                  s1_valid_q, s1_valid_d;
  logic [COL_W-1:0]      s1_col_q;
  logic [PIXEL_BITS-1:0] s1_pixel_q;
  shp3_pkg::flags_t      s1_flags_q;
  logic [COL_W-1:0]      s1_ecol_q;
  logic [ROW_W-1:0]      s1_erow_q;
  logic                  s1_adv;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= shp3_pkg::WIDTH_RST;
      height_q <= shp3_pkg::HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        shp3_pkg::CFG_IDX_WIDTH:  width_q  <= cfg_data_i[shp3_pkg::WIDTH_REG_W-1:0];
        shp3_pkg::CFG_IDX_HEIGHT: height_q <= cfg_data_i[shp3_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective size: zero acts as one, width capped at the line store depth
  always_comb begin
    if (width_q == '0) begin
      w_eff = WCNT_W'(1);
    end else if (CMP_W'(width_q) > CMP_W'(MAX_WIDTH)) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(width_q);
    end
    h_last = (height_q == '0) ? '0 : height_q - ROW_W'(1);
  end

  // read stage
  assign s1_adv     = s1_valid_q && (!s1_flags_q.emit || out_free_i);
  assign in_ready_o = !clearing_i && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;
  assign ignore     = (in_cmd_i == shp3_pkg::CMD_FLUSH) ? !flushing_q : flushing_q;
  assign take       = accept && !ignore;

  always_comb begin
    // a column left over from a wider setting wraps to zero
    col_eff   = (WCNT_W'(in_col_q) >= w_eff) ? '0 : in_col_q;
    col_inc   = WCNT_W'(col_eff) + WCNT_W'(1);
    wrap      = col_inc >= w_eff;
    pix_valid = (in_row_q >= ROW_W'(2)) || (in_row_q == ROW_W'(1) && col_eff != '0);
    frame_end = !flushing_q && (in_row_q >= h_last) && wrap;
    flush_n   = flushing_q || frame_end;

    ecol_inc  = WCNT_W'(ecol_q) + WCNT_W'(1);
    ewrap     = ecol_inc >= w_eff;

    flags.emit      = pix_valid;
    flags.last      = pix_valid && flush_n && (erow_q >= h_last) && ewrap;
    flags.use_up    = erow_q != '0;
    flags.use_down  = erow_q < h_last;
    flags.use_left  = ecol_q != '0;
    flags.use_right = !ewrap;

    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    ecol_d     = ecol_q;
    erow_d     = erow_q;
    flushing_d = flushing_q;
    if (take) begin
      if (flags.last) begin
        in_col_d   = '0;
        in_row_d   = '0;
        ecol_d     = '0;
        erow_d     = '0;
        flushing_d = 1'b0;
      end else begin
        flushing_d = flush_n;
        if (wrap) begin
          in_col_d = '0;
          if (in_row_q != ROW_MAX) begin
            in_row_d = in_row_q + ROW_W'(1);
          end
        end else begin
          in_col_d = col_inc[COL_W-1:0];
        end
        if (pix_valid) begin
          if (ewrap) begin
            ecol_d = '0;
            erow_d = erow_q + ROW_W'(1);
          end else begin
            ecol_d = ecol_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      ecol_q     <= '0;
      erow_q     <= '0;
      flushing_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      ecol_q     <= ecol_d;
      erow_q     <= erow_d;
      flushing_q <= flushing_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_col_q   <= col_eff;
      s1_pixel_q <= (in_cmd_i == shp3_pkg::CMD_FLUSH) ? '0 : in_pixel_i;
      s1_flags_q <= flags;
      s1_ecol_q  <= ecol_q;
      s1_erow_q  <= erow_q;
    end
  end

  assign rd_en_o    = take;
  assign rd_addr_o  = col_eff;
  assign s1_adv_o   = s1_adv;
  assign s1_col_o   = s1_col_q;
  assign s1_pixel_o = s1_pixel_q;
  assign s1_flags_o = s1_flags_q;
  assign s1_ecol_o  = s1_ecol_q;
  assign s1_erow_o  = s1_erow_q;

  // the frame's final result restarts all positions
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && flags.last |=> in_col_q == '0 && in_row_q == '0 && !flushing_q)
    else $error("positions not cleared after the final result");

  // no new item while the line stores are being cleared
  a_no_take_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_i |-> !rd_en_o && !s1_valid_q)
    else $error("item taken during line store clear");

  // a held read-stage item keeps its column and flags
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_flags_q))
    else $error("stalled read-stage item changed");

  // flushing starts only on an item that ends the frame
  a_flush_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flushing_q && take && !frame_end |=> !flushing_q)
    else $error("flush entered without frame end");

endmodule

@@ rtl/sharpen_3x3_convolution_top.sv @@
// ----------------------------------------------------------------------------
// sharpen_3x3_convolution_top: 3x3 sharpen filter with zero padding
// The result register behind tvalid loads from the read stage; a held
// result with tready low stalls that stage and, through it, s_axis_tready.
// Throughput: one item per cycle unless so stalled; line stores are read on
// accept and written when the item leaves the read stage, with same-column
// forwarding. Reset: positions and window clear at once; then both line
// stores are cleared with s_axis_tready low. Config is always taken.
// ----------------------------------------------------------------------------
module sharpen_3x3_convolution_top #(
  parameter int unsigned MAX_WIDTH  = shp3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = shp3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [shp3_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [shp3_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_axis_tdata,   // pixel
  input  logic                                  s_axis_tuser,   // cmd
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [shp3_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // sharpened, out_col, out_row
  output logic                                  m_axis_tlast    // frame_last
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned PAD_W = shp3_pkg::OUT_TDATA_W - shp3_pkg::OUT_FIELD_W;

  logic                            clearing, out_free, rd_en, s1_adv;
  logic [COL_W-1:0]                rd_addr, s1_col, s1_ecol;
  logic [PIXEL_BITS-1:0]           s1_pixel, top, mid;
  shp3_pkg::flags_t                s1_flags;
  logic [shp3_pkg::OUT_ROW_W-1:0]  s1_erow;
  logic [shp3_pkg::SHARP_W-1:0]    res_sharp;
  logic [shp3_pkg::OUT_COL_W-1:0]  res_col;
  logic [shp3_pkg::OUT_ROW_W-1:0]  res_row;

  shp3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_pixel_i  (s_axis_tdata[PIXEL_BITS-1:0]),
    .clearing_i  (clearing),
    .out_free_i  (out_free),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .s1_adv_o    (s1_adv),
    .s1_col_o    (s1_col),
    .s1_pixel_o  (s1_pixel),
    .s1_flags_o  (s1_flags),
    .s1_ecol_o   (s1_ecol),
    .s1_erow_o   (s1_erow)
  );

  shp3_linebuf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_linebuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .wr_en_i    (s1_adv),
    .wr_addr_i  (s1_col),
    .wr_pixel_i (s1_pixel),
    .clearing_o (clearing),
    .top_o      (top),
    .mid_o      (mid)
  );

  shp3_kernel #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (s1_adv),
    .top_i       (top),
    .mid_i       (mid),
    .pixel_i     (s1_pixel),
    .flags_i     (s1_flags),
    .ecol_i      (s1_ecol),
    .erow_i      (s1_erow),
    .out_free_o  (out_free),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_sharp_o (res_sharp),
    .res_col_o   (res_col),
    .res_row_o   (res_row),
    .res_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, res_row, res_col, res_sharp};

endmodule
